[design/assert_macros.svh]
// Assertion helpers used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// expr must hold at every clock edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

[design/tdpa_pkg.sv]
package tdpa_pkg;

    localparam int LANES     = 4;
    localparam int CODE_W    = 2;
    localparam int ACT_W     = 8;
    localparam int CONTRIB_W = ACT_W + 1;   // holds -(-128)
    localparam int SUM_W     = 32;
    localparam int TDATA_W   = 48;
    localparam int SLOT_W    = 2;
    localparam int COUNT_W   = 3;

    // 2-bit ternary weight codes
    typedef enum logic [CODE_W-1:0] {
        CODE_ZERO  = 2'b00,
        CODE_PLUS  = 2'b01,
        CODE_MINUS = 2'b10,
        CODE_NULL  = 2'b11
    } t_code;

    typedef logic signed [CONTRIB_W-1:0] t_contrib;

    // control from the lane stage into the accumulator
    typedef struct packed {
        logic fire;
        logic last;
    } t_acc_ctrl;

endpackage

[design/ternary_dot_product_accumulator_top.sv]
// Ternary dot-product accumulator.
// Input stream (s_axis): one beat carries a packed weight byte of four 2-bit
// ternary codes (01 = +1, 10 = -1, 00/11 = 0), four int8 activations, the
// first taking-part slot and the count of taking-part slots; tlast marks the
// final beat of a dot product. Output stream (m_axis): one beat per dot
// product holding the 32-bit two's complement sum, which wraps modulo 2^32.
// Throughput: one input beat per cycle while no last beat waits in the lane stage.
// Four lanes form the slot contributions of a beat and register them at the
// accepting edge; the merge stage adds them into the running sum when the beat
// leaves the lane stage. The sum appears on m_axis_tvalid after two register
// stages from the input: the lane register and the result register.
// Reset (synchronous, i_rst_n low) clears the running sum and empties the
// pipeline and the result register.
// When the receiver stalls, beats without tlast still flow into the sum; a
// last beat waits in the lane stage only while an earlier result is still
// untaken, and then s_axis_tready drops for as long as that lasts.
`include "assert_macros.svh"

module ternary_dot_product_accumulator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // weight_byte[7:0], first_slot[9:8], valid_count[12:10], act_0[20:13],
    // act_1[28:21], act_2[36:29], act_3[44:37], zero pad[47:45]
    input  logic [tdpa_pkg::TDATA_W-1:0]  s_axis_tdata,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // dot_sum[31:0]
    output logic [tdpa_pkg::SUM_W-1:0]    m_axis_tdata
);

    localparam int ActLo = 13;

    logic [7:0]                          w_weight;
    logic [tdpa_pkg::SLOT_W-1:0]         w_first;
    logic [tdpa_pkg::COUNT_W-1:0]        w_count;
    logic [tdpa_pkg::LANES-1:0]          w_take;
    logic                                w_s_fire;
    logic                                w_s1_fire;
    logic                                r_s1_valid;
    logic                                r_s1_last;
    tdpa_pkg::t_contrib                  w_contrib [tdpa_pkg::LANES];
    tdpa_pkg::t_acc_ctrl                 w_ctrl;

    // beat unpacking
    assign w_weight = s_axis_tdata[7:0];
    assign w_first  = s_axis_tdata[9:8];
    assign w_count  = s_axis_tdata[12:10];

    // lane stage moves on unless a last beat must wait for the result register
    assign w_s1_fire     = r_s1_valid && (!r_s1_last || !m_axis_tvalid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || w_s1_fire;
    assign w_s_fire      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
        end else if (s_axis_tready) begin
            r_s1_valid <= s_axis_tvalid;
            r_s1_last  <= s_axis_tlast;
        end
    end

    // slot window and lanes
    for (genvar j = 0; j < tdpa_pkg::LANES; j++) begin : g_lane
        logic [tdpa_pkg::COUNT_W-1:0] w_off;

        assign w_off     = tdpa_pkg::COUNT_W'(j) - {1'b0, w_first};
        assign w_take[j] = (tdpa_pkg::COUNT_W'(j) >= {1'b0, w_first}) && (w_off < w_count);

        tdpa_lane u_lane (
            .i_clk     (i_clk),
            .i_load    (w_s_fire),
            .i_take    (w_take[j]),
            .i_code    (tdpa_pkg::t_code'(w_weight[2*j +: tdpa_pkg::CODE_W])),
            .i_act     (s_axis_tdata[ActLo + tdpa_pkg::ACT_W*j +: tdpa_pkg::ACT_W]),
            .o_contrib (w_contrib[j])
        );
    end

    assign w_ctrl.fire = w_s1_fire;
    assign w_ctrl.last = r_s1_last;

    tdpa_accum u_accum (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (w_ctrl),
        .i_contrib (w_contrib),
        .i_ready   (m_axis_tready),
        .o_valid   (m_axis_tvalid),
        .o_data    (m_axis_tdata)
    );

    // a last beat leaving the lane stage always shows up as a result
    `ASSERT_NEXT(a_last_emits, i_clk, i_rst_n, w_s1_fire && r_s1_last, m_axis_tvalid)
    // an untaken result is never overwritten
    `ASSERT_ALWAYS(a_no_overwrite, i_clk, i_rst_n,
        !(w_s1_fire && r_s1_last && m_axis_tvalid && !m_axis_tready))
    // a held lane-stage beat stays in place
    `ASSERT_NEXT(a_s1_hold, i_clk, i_rst_n, r_s1_valid && !w_s1_fire,
        r_s1_valid && $stable(r_s1_last))

endmodule

[design/tdpa_lane.sv]
module tdpa_lane (
    input  logic                              i_clk,
    input  logic                              i_load,
    input  logic                              i_take,
    input  tdpa_pkg::t_code                   i_code,
    input  logic signed [tdpa_pkg::ACT_W-1:0] i_act,
    output tdpa_pkg::t_contrib                o_contrib
);

    tdpa_pkg::t_contrib w_act_x;
    tdpa_pkg::t_contrib n_contrib;
    tdpa_pkg::t_contrib r_contrib;

    assign w_act_x = {i_act[tdpa_pkg::ACT_W-1], i_act};

    // add, subtract or skip this slot's activation
    always_comb begin
        n_contrib = '0;
        if (i_take) begin
            case (i_code)
                tdpa_pkg::CODE_PLUS:  n_contrib = w_act_x;
                tdpa_pkg::CODE_MINUS: n_contrib = -w_act_x;
                default:              n_contrib = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_contrib <= n_contrib;
        end
    end

    assign o_contrib = r_contrib;

endmodule

[design/tdpa_accum.sv]
module tdpa_accum (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  tdpa_pkg::t_acc_ctrl               i_ctrl,
    input  tdpa_pkg::t_contrib                i_contrib [tdpa_pkg::LANES],
    input  logic                              i_ready,
    output logic                              o_valid,
    output logic [tdpa_pkg::SUM_W-1:0]        o_data
);

    logic signed [tdpa_pkg::SUM_W-1:0] w_item;
    logic signed [tdpa_pkg::SUM_W-1:0] w_total;
    logic signed [tdpa_pkg::SUM_W-1:0] r_acc;
    logic [tdpa_pkg::SUM_W-1:0]        r_data;
    logic                              r_valid;

    // merge the lane results of one beat
    always_comb begin
        w_item = '0;
        for (int k = 0; k < tdpa_pkg::LANES; k++) begin
            w_item = w_item + tdpa_pkg::SUM_W'(i_contrib[k]);
        end
    end

    assign w_total = r_acc + w_item;

    // running sum, cleared once the total leaves on a last beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (i_ctrl.fire) begin
                r_acc <= i_ctrl.last ? '0 : w_total;
            end
            if (i_ctrl.fire && i_ctrl.last) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_ctrl.fire && i_ctrl.last) begin
            r_data <= w_total;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

[test/tb_ternary_dot_product_accumulator_top.sv]
`timescale 1ns / 1ps

module tb_ternary_dot_product_accumulator_top;

    localparam int RANDOM_BEATS = 1200;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int MAX_GAP      = 10;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT      = 30;
    localparam int DRAIN_CYCLES = 10;

    // one input beat, fields as the block sees them
    typedef struct packed {
        logic [7:0]                                      weight;
        logic [tdpa_pkg::SLOT_W-1:0]                     first;
        logic [tdpa_pkg::COUNT_W-1:0]                    count;
        logic [tdpa_pkg::LANES-1:0][tdpa_pkg::ACT_W-1:0] act;
        logic                                            last;
    } t_beat;

    // directed row: sum is typed in only where it is obvious
    typedef struct {
        t_beat                      beat;
        bit                         typed;
        logic [tdpa_pkg::SUM_W-1:0] sum;
    } t_row;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [tdpa_pkg::TDATA_W-1:0]   s_axis_tdata = '0;
    logic                           s_axis_tlast = 1'b0;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [tdpa_pkg::SUM_W-1:0]     m_axis_tdata;

    logic [tdpa_pkg::SUM_W-1:0] dot_acc = '0;      // predicted partial sum
    logic [tdpa_pkg::SUM_W-1:0] pending_sums[$];   // sums still owed by the block
    t_row                       directed_rows[$];
    int                         fail_cnt = 0;
    int                         sums_seen = 0;
    int                         beats_sent = 0;
    int                         cycle_cnt = 0;
    bit                         tx_burst = 1'b0;
    bit                         rx_burst = 1'b0;
    bit                         hold_done = 1'b0;

    ternary_dot_product_accumulator_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // weight, first, count, act_0..act_3, pad
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // dot_sum
    );

    always #4 i_clk = ~i_clk;

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // contribution of one beat: taking-part slots add, subtract or skip
    function automatic logic [tdpa_pkg::SUM_W-1:0] ternary_partial(t_beat b);
        logic [tdpa_pkg::SUM_W-1:0] acc;
        logic [tdpa_pkg::SUM_W-1:0] a;
        tdpa_pkg::t_code            code;
        acc = '0;
        for (int j = 0; j < tdpa_pkg::LANES; j++) begin
            code = tdpa_pkg::t_code'(b.weight[tdpa_pkg::CODE_W*j +: tdpa_pkg::CODE_W]);
            a    = {{(tdpa_pkg::SUM_W-tdpa_pkg::ACT_W){b.act[j][tdpa_pkg::ACT_W-1]}},
                    b.act[j]};
            if (j >= int'(b.first) && (j - int'(b.first)) < int'(b.count)) begin
                if (code == tdpa_pkg::CODE_PLUS)
                    acc = acc + a;
                else if (code == tdpa_pkg::CODE_MINUS)
                    acc = acc - a;
            end
        end
        return acc;
    endfunction

    function automatic t_beat make_beat(logic [7:0] w, int f, int c,
                                        int a0, int a1, int a2, int a3, bit l);
        t_beat b;
        b.weight = w;
        b.first  = tdpa_pkg::SLOT_W'(f);
        b.count  = tdpa_pkg::COUNT_W'(c);
        b.act[0] = tdpa_pkg::ACT_W'(a0);
        b.act[1] = tdpa_pkg::ACT_W'(a1);
        b.act[2] = tdpa_pkg::ACT_W'(a2);
        b.act[3] = tdpa_pkg::ACT_W'(a3);
        b.last   = l;
        return b;
    endfunction

    task automatic add_row(t_beat b, bit typed, int sum);
        t_row r;
        r.beat  = b;
        r.typed = typed;
        r.sum   = tdpa_pkg::SUM_W'(sum);
        directed_rows.push_back(r);
    endtask

    // offer one beat after a random gap, wait for the handshake, predict
    task automatic drive_beat(t_beat b, bit typed, logic [tdpa_pkg::SUM_W-1:0] typed_sum);
        int gap;
        if (beats_sent % 64 == 0)
            tx_burst = ($urandom_range(0, 3) == 0);
        gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(tdpa_pkg::TDATA_W-45){1'b0}}, b.act, b.count, b.first, b.weight};
        s_axis_tlast  <= b.last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        beats_sent++;
        dot_acc = dot_acc + ternary_partial(b);
        if (b.last) begin
            pending_sums.push_back(typed ? typed_sum : dot_acc);
            dot_acc = '0;
        end
    endtask

    // random beat of a dot product; mostly well-formed continuous packing
    function automatic t_beat random_beat(bit is_first, bit is_end, bit extreme);
        t_beat b;
        int    f;
        bit    noise;
        noise = ($urandom_range(0, 9) == 0);
        if (noise) begin
            b.first = tdpa_pkg::SLOT_W'($urandom_range(0, 3));
            b.count = tdpa_pkg::COUNT_W'($urandom_range(0, 7));
        end else begin
            f       = is_first ? $urandom_range(0, 3) : 0;
            b.first = tdpa_pkg::SLOT_W'(f);
            b.count = tdpa_pkg::COUNT_W'(is_end ? $urandom_range(1, tdpa_pkg::LANES - f)
                                                : tdpa_pkg::LANES - f);
        end
        b.weight = extreme ? 8'h55 : 8'($urandom_range(0, 255));
        for (int j = 0; j < tdpa_pkg::LANES; j++) begin
            if (extreme)
                b.act[j] = 8'sd127;
            else if ($urandom_range(0, 7) == 0)
                b.act[j] = $urandom_range(0, 1) ? 8'h7F : 8'h80;
            else
                b.act[j] = 8'($urandom_range(0, 255));
        end
        b.last = is_end;
        return b;
    endfunction

    task automatic run_dot_product(int len, bit extreme);
        for (int i = 0; i < len; i++)
            drive_beat(random_beat(i == 0, i == len - 1, extreme), 1'b0, '0);
    endtask

    // stimulus
    initial begin
        int len;
        bit long_done;
        long_done = 1'b0;

        // all ones, all minus ones, extremes of the activations
        add_row(make_beat(8'h00, 0, 0, 0, 0, 0, 0, 1), 1, 0);
        add_row(make_beat(8'h55, 0, 4, 127, 127, 127, 127, 1), 1, 508);
        add_row(make_beat(8'hAA, 0, 4, -128, -128, -128, -128, 1), 1, 512);
        add_row(make_beat(8'h55, 0, 4, -128, -128, -128, -128, 1), 1, -512);
        add_row(make_beat(8'hAA, 0, 4, 127, 127, 127, 127, 1), 1, -508);
        // zero codes, both encodings
        add_row(make_beat(8'h00, 0, 4, 99, -7, 127, -128, 1), 1, 0);
        add_row(make_beat(8'hFF, 0, 4, 99, -7, 127, -128, 1), 1, 0);
        // every code in one byte
        add_row(make_beat(8'hE4, 0, 4, 10, 20, 30, 40, 1), 1, -10);
        // zero count still emits
        add_row(make_beat(8'h55, 0, 0, 127, 127, 127, 127, 1), 1, 0);
        // counts running past the end of the byte are clipped
        add_row(make_beat(8'h55, 0, 7, 1, 2, 3, 4, 1), 1, 10);
        add_row(make_beat(8'h55, 3, 4, 1, 2, 3, 4, 1), 1, 4);
        add_row(make_beat(8'h55, 2, 1, 1, 2, 3, 4, 1), 1, 3);
        add_row(make_beat(8'hAA, 1, 6, 1, 2, 3, 4, 1), 1, -9);
        // dot product starting and ending mid-byte
        add_row(make_beat(8'h90, 2, 2, 5, 6, -77, 100, 0), 0, 0);
        add_row(make_beat(8'h1B, 0, 4, -128, 127, -1, 64, 0), 0, 0);
        add_row(make_beat(8'h66, 0, 4, 127, -128, 127, -128, 0), 0, 0);
        add_row(make_beat(8'h59, 0, 3, 33, -44, 55, -66, 1), 0, 0);
        // noise inside a run, then a zero-count last
        add_row(make_beat(8'hC6, 3, 5, 1, 2, 3, -128, 0), 0, 0);
        add_row(make_beat(8'h95, 1, 0, 9, 9, 9, 9, 0), 0, 0);
        add_row(make_beat(8'h3C, 0, 0, 8, 8, 8, 8, 1), 0, 0);
        // back-to-back single-beat sums
        add_row(make_beat(8'h99, 1, 3, -128, 127, -128, 127, 1), 0, 0);
        add_row(make_beat(8'h65, 0, 4, -3, 7, -128, 127, 1), 0, 0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            drive_beat(directed_rows[k].beat, directed_rows[k].typed, directed_rows[k].sum);

        // random part; one long product near the largest magnitudes
        while (beats_sent < RANDOM_BEATS) begin
            if (!long_done && beats_sent > RANDOM_BEATS / 2) begin
                run_dot_product(256, 1'b1);
                long_done = 1'b1;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40)
                                                  : $urandom_range(1, 6);
                run_dot_product(len, 1'b0);
            end
        end
        s_axis_tvalid <= 1'b0;

        // drain, then give any stray beat time to show up
        while (pending_sums.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // receiver with random backpressure and one long hold-off
    initial begin
        int                         gap;
        logic [tdpa_pkg::SUM_W-1:0] want;
        wait (i_rst_n);
        forever begin
            if (sums_seen % 16 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
            if (!hold_done && sums_seen == HOLD_AT) begin
                gap       = HOLD_CYCLES;
                hold_done = 1'b1;
            end else begin
                gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
            sums_seen++;
            if (pending_sums.size() == 0) begin
                fail_cnt++;
                if (fail_cnt <= 10)
                    $display("unexpected result beat: dot_sum %0d", $signed(m_axis_tdata));
            end else begin
                want = pending_sums.pop_front();
                if (m_axis_tdata !== want) begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("dot_sum mismatch: expected %0d, got %0d",
                                 $signed(want), $signed(m_axis_tdata));
                end
            end
        end
    end

endmodule
